/* rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/patb_pkg.sv */
// Package: constants, types and command structs for the address rate limiter
`timescale 1ns / 1ps
package patb_pkg;
   localparam int TableEntries = 64;
   localparam int IdxW = $clog2(TableEntries);
   localparam int CntW = IdxW + 1;
   localparam int CfgW = 15;
   localparam int TimeW = 32;
   localparam int TokW = 16;
   localparam logic [1:0] REG_BUCKET = 2'd0;
   localparam logic [1:0] REG_REFILL = 2'd1;
   localparam logic [1:0] REG_BAN    = 2'd2;
   localparam logic ACT_REQUEST = 1'b0;
   localparam logic ACT_TICK    = 1'b1;
   // entry word: valid, banned, tokens, address, refill, ban_end
   typedef struct packed {
      logic                    valid;
      logic                    banned;
      logic signed [TokW-1:0]  tokens;
      logic [31:0]             address;
      logic [TimeW-1:0]        refill;
      logic [TimeW-1:0]        ban_end;
   } entry_type;
   localparam int EntryW = $bits(entry_type);

   typedef enum logic [2:0] {
      OP_NONE   = 3'b000,
      OP_READ   = 3'b001,   // issue read at index
      OP_SWEEP  = 3'b010,   // sweep step on read data
      OP_LOOK   = 3'b011,   // lookup step on read data
      OP_APPLY  = 3'b100    // finish request on held entry
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [IdxW-1:0] idx;
      logic            tick_inc;
      logic            look_clr;
   } cmd_type;
endpackage

/* rtl/patb_if.sv */
// Valid/ready channel interfaces
`timescale 1ns / 1ps
interface patb_req_if (input logic clock);
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] client_address;
   modport source (output valid, action, client_address, input ready);
   modport sink (input valid, action, client_address, output ready);
endinterface

interface patb_rsp_if (input logic clock);
   logic valid;
   logic ready;
   logic reject;
   logic newly_banned;
   logic table_full;
   modport source (output valid, reject, newly_banned, table_full, input ready);
   modport sink (input valid, reject, newly_banned, table_full, output ready);
endinterface

interface patb_csr_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [14:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/patb_ram.sv */
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module patb_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

/* rtl/patb_datapath.sv */
// Datapath: entry table, time counter, lookup and update arithmetic
`timescale 1ns / 1ps
module patb_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  patb_pkg::cmd_type                 cmd,
   input  logic [31:0]                       address,
   input  logic [patb_pkg::CfgW-1:0]         bkt_limit,
   input  logic [patb_pkg::CfgW-1:0]         refill_seconds,
   input  logic [patb_pkg::CfgW-1:0]         ban_seconds,
   input  logic                              clr_active,
   input  logic [patb_pkg::IdxW-1:0]         clr_idx,
   output logic                              reject,
   output logic                              newly_banned,
   output logic                              table_full
);
   localparam int IdxW = patb_pkg::IdxW;
   localparam int TimeW = patb_pkg::TimeW;

   logic [TimeW-1:0]    now_ff, now_in;
   logic                we;
   logic [IdxW-1:0]     ram_addr;
   patb_pkg::entry_type wr_entry, rd_entry;
   logic [patb_pkg::EntryW-1:0] rd_bits;
   logic                hit_ff, hit_in, free_ff, free_in;
   logic [IdxW-1:0]     hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   patb_pkg::entry_type hit_ent_ff, hit_ent_in;
   logic [IdxW-1:0]     prev_idx_ff;
   logic                rej_ff, rej_in, nb_ff, nb_in, tf_ff, tf_in;
   logic [patb_pkg::TokW-1:0] bsz;
   logic [TimeW-1:0]    refill_at, ban_at, d;

   patb_ram #(.Width(patb_pkg::EntryW), .Depth(patb_pkg::TableEntries)) u_ram (
      .clock(clock), .we(we), .addr(ram_addr), .wdata(wr_entry), .rdata(rd_bits)
   );
   assign rd_entry = patb_pkg::entry_type'(rd_bits);
   assign bsz = patb_pkg::TokW'(bkt_limit);
   assign refill_at = now_ff + TimeW'(refill_seconds);

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else begin
         now_ff <= now_in;
      end
      // address behind the read data of the next cycle
      prev_idx_ff <= ram_addr;
      hit_ff <= hit_in; free_ff <= free_in;
      hit_idx_ff <= hit_idx_in; free_idx_ff <= free_idx_in;
      hit_ent_ff <= hit_ent_in;
      rej_ff <= rej_in; nb_ff <= nb_in; tf_ff <= tf_in;
   end
   assign reject = rej_ff;
   assign newly_banned = nb_ff;
   assign table_full = tf_ff;

   always_comb begin
      patb_pkg::entry_type e;
      e = '0;
      now_in = now_ff + TimeW'(cmd.tick_inc);
      we = 1'b0;
      ram_addr = cmd.idx;
      wr_entry = rd_entry;
      hit_in = hit_ff; free_in = free_ff;
      hit_idx_in = hit_idx_ff; free_idx_in = free_idx_ff;
      hit_ent_in = hit_ent_ff;
      rej_in = rej_ff; nb_in = nb_ff; tf_in = tf_ff;
      ban_at = '0; d = '0;
      if (cmd.look_clr) begin
         hit_in = 1'b0; free_in = 1'b0;
      end
      if (clr_active) begin
         we = 1'b1; ram_addr = clr_idx; wr_entry = '0;
      end else begin
         case (cmd.op)
            patb_pkg::OP_SWEEP: begin
               ram_addr = prev_idx_ff;
               if (rd_entry.valid) begin
                  if (rd_entry.tokens == $signed(bsz)) begin
                     we = 1'b1; wr_entry.valid = 1'b0;
                  end else begin
                     d = now_ff - rd_entry.refill;
                     if (!d[TimeW-1]) begin
                        we = 1'b1; wr_entry.banned = 1'b0;
                        wr_entry.tokens = bsz; wr_entry.refill = refill_at;
                     end
                  end
               end
            end
            patb_pkg::OP_LOOK: begin
               if (rd_entry.valid) begin
                  if (!hit_ff && rd_entry.address == address) begin
                     hit_in = 1'b1; hit_idx_in = prev_idx_ff; hit_ent_in = rd_entry;
                  end
               end else if (!free_ff) begin
                  free_in = 1'b1; free_idx_in = prev_idx_ff;
               end
            end
            patb_pkg::OP_APPLY: begin
               rej_in = 1'b0; nb_in = 1'b0; tf_in = 1'b0;
               if (bkt_limit == '0) begin
                  // disabled: pass
               end else if (!hit_ff && !free_ff) begin
                  tf_in = 1'b1;
               end else begin
                  if (hit_ff) begin
                     e = hit_ent_ff; ram_addr = hit_idx_ff;
                  end else begin
                     e.valid = 1'b1; e.address = address; e.ban_end = '0;
                     e.banned = 1'b0; e.tokens = bsz; e.refill = refill_at;
                     ram_addr = free_idx_ff;
                  end
                  if (!e.banned) begin
                     e.tokens = e.tokens - 16'sd1;
                     if (e.tokens[patb_pkg::TokW-1]) begin
                        ban_at = now_ff + TimeW'(ban_seconds);
                        e.banned = 1'b1; e.ban_end = ban_at; e.refill = ban_at;
                        nb_in = 1'b1;
                     end
                  end
                  if (e.banned) begin
                     d = e.ban_end - now_ff;
                     if (d != '0 && !d[TimeW-1]) begin
                        rej_in = 1'b1;
                     end else begin
                        e.banned = 1'b0; e.tokens = bsz; e.refill = refill_at;
                     end
                  end
                  we = 1'b1; wr_entry = e;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

/* rtl/patb_ctrl.sv */
// Controller: sequences clearing, lookup, sweep and response handshake
`timescale 1ns / 1ps
module patb_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output patb_pkg::cmd_type          cmd,
   output logic                       clr_active,
   output logic [patb_pkg::IdxW-1:0]  clr_idx
);
   localparam int IdxW = patb_pkg::IdxW;
   localparam int CntW = patb_pkg::CntW;
   localparam logic [CntW-1:0] Last = CntW'(patb_pkg::TableEntries);
   localparam logic [CntW-1:0] SweepLast = CntW'(2 * patb_pkg::TableEntries - 1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_LOOK  = 6'b000100,
      S_SWEEP = 6'b001000,
      S_APPLY = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rv_ff, rv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; cnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
      end
   end
   assign rsp_valid = rv_ff;
   assign clr_active = (state_ff == S_CLEAR);
   assign clr_idx = cnt_ff[IdxW-1:0];

   // lookup: one read per cycle, step on read data comes in the cycle after its issue
   // sweep: read cycle then update cycle per entry (single-port table)
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff;
      rv_in = rv_ff && !rsp_ready;
      req_ready = 1'b0;
      cmd = '0;
      cmd.idx = cnt_ff[IdxW-1:0];
      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == Last - 1'b1) begin
               state_in = S_IDLE; cnt_in = '0;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cnt_in = '0;
               cmd.look_clr = 1'b1;
               if (req_action == patb_pkg::ACT_TICK) begin
                  cmd.tick_inc = 1'b1; state_in = S_SWEEP;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            cmd.op = (cnt_ff != '0) ? patb_pkg::OP_LOOK : patb_pkg::OP_READ;
            if (cnt_ff == Last) begin
               cnt_in = '0;
               state_in = S_APPLY;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SWEEP: begin
            cmd.idx = cnt_ff[IdxW:1];
            cmd.op = cnt_ff[0] ? patb_pkg::OP_SWEEP : patb_pkg::OP_READ;
            if (cnt_ff == SweepLast) begin
               cnt_in = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_APPLY: begin
            // hold result registers until the previous result is taken
            if (!rv_ff || rsp_ready) begin
               cmd.op = patb_pkg::OP_APPLY;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

/* rtl/per_address_token_bucket_ban_top.sv */
// Sequence: request looks up every table entry, then updates, then result valid; tick sweeps, no result.
// Flow: one transaction at a time, the next is taken only once the lookup and update or the
// sweep (read then update of each entry on the single-port RAM) are done; a result held by
// rsp_ready stalls the following request before its table update.
// Reset: synchronous; afterwards every table entry is cleared, input not taken meanwhile.
// Top level: per-address token bucket limiter with bans; configuration writes always accepted
`timescale 1ns / 1ps
module per_address_token_bucket_ban_top (
   input logic       clock,
   input logic       reset,
   patb_req_if.sink  req,
   patb_rsp_if.source rsp,
   patb_csr_if.sink  csr
);
   logic [patb_pkg::CfgW-1:0] bucket_ff, refill_ff, ban_ff;
   patb_pkg::cmd_type    cmd;
   logic clr_active;
   logic [patb_pkg::IdxW-1:0] clr_idx;
   logic [31:0] addr_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_ff <= '0; refill_ff <= 15'd60; ban_ff <= 15'd900;
      end else if (csr.valid) begin
         case (csr.index)
            patb_pkg::REG_BUCKET: bucket_ff <= csr.data;
            patb_pkg::REG_REFILL: refill_ff <= csr.data;
            patb_pkg::REG_BAN:    ban_ff <= csr.data;
            default: ;
         endcase
      end
      if (req.valid && req.ready) addr_ff <= req.client_address;
   end

   patb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .req_action(req.action), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .clr_active(clr_active), .clr_idx(clr_idx)
   );

   patb_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .address(addr_ff),
      .bkt_limit(bucket_ff), .refill_seconds(refill_ff), .ban_seconds(ban_ff),
      .clr_active(clr_active), .clr_idx(clr_idx),
      .reject(rsp.reject), .newly_banned(rsp.newly_banned), .table_full(rsp.table_full)
   );
endmodule

/* rtl/patb_checker.sv */
// Port-level checker bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module patb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic reject,
   input logic newly_banned,
   input logic table_full
);
   `CHK_IMPL(a_full_pass, clock, reset, rsp_valid && table_full, !reject && !newly_banned, "table full must pass")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(reject), "response dropped")
   `CHK_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item taken while busy")
endmodule

bind per_address_token_bucket_ban_top patb_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .reject(rsp.reject),
   .newly_banned(rsp.newly_banned), .table_full(rsp.table_full)
);

/* tb/sv/tb.sv */
// Testbench for the per-address token bucket limiter: predicted results checked in order
`timescale 1ns / 1ps
module tb;
   localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped index, write must be dropped
   localparam int MAX_CYCLES = 2000000;
   localparam int SETTLE_CYCLES = 80;
   localparam int Entries = patb_pkg::TableEntries;

   typedef struct packed {
      logic        action;
      logic [31:0] client_address;
   } req_item_type;

   typedef struct packed {
      logic reject;
      logic newly_banned;
      logic table_full;
   } verdict_type;

   logic clock;
   logic reset;

   patb_req_if req (.clock(clock));
   patb_rsp_if rsp (.clock(clock));
   patb_csr_if csr (.clock(clock));

   per_address_token_bucket_ban_top uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // limiter state mirror
   logic [14:0] lim_bucket;
   logic [14:0] lim_refill;
   logic [14:0] lim_ban;
   logic [31:0] lim_now;
   logic        tbl_valid   [Entries];
   logic [31:0] tbl_addr    [Entries];
   int          tbl_tokens  [Entries];
   logic [31:0] tbl_refill  [Entries];
   logic        tbl_banned  [Entries];
   logic [31:0] tbl_ban_end [Entries];

   req_item_type pending_q[$];
   verdict_type  verdict_q[$];
   int        fail_count;
   int        req_accepts;
   int        cycle_count;
   logic      req_done;
   int        req_gap;
   int        rsp_gap;
   int        hold_left;
   logic      held_once;

   function automatic logic reached(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return !d[31];
   endfunction

   function automatic void bucket_refill(input int i);
      tbl_banned[i] = 1'b0;
      tbl_tokens[i] = int'(lim_bucket);
      tbl_refill[i] = lim_now + 32'(lim_refill);
   endfunction

   function automatic void sweep_table();
      lim_now = lim_now + 1;
      for (int i = 0; i < Entries; i++) begin
         if (tbl_valid[i]) begin
            if (tbl_tokens[i] == int'(lim_bucket)) tbl_valid[i] = 1'b0;
            else if (reached(lim_now, tbl_refill[i])) bucket_refill(i);
         end
      end
   endfunction

   function automatic verdict_type judge_request(input logic [31:0] addr);
      verdict_type v;
      int hit;
      int free_slot;
      logic [31:0] d;
      v = '0;
      hit = -1;
      free_slot = -1;
      if (lim_bucket != 0) begin
         for (int i = 0; i < Entries; i++) begin
            if (tbl_valid[i]) begin
               if (hit < 0 && tbl_addr[i] == addr) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit < 0 && free_slot >= 0) begin
            hit = free_slot;
            tbl_valid[hit] = 1'b1;
            tbl_addr[hit] = addr;
            tbl_ban_end[hit] = '0;
            bucket_refill(hit);
         end
         if (hit < 0) begin
            v.table_full = 1'b1;
         end else begin
            if (!tbl_banned[hit]) begin
               tbl_tokens[hit] = tbl_tokens[hit] - 1;
               if (tbl_tokens[hit] < 0) begin
                  tbl_banned[hit] = 1'b1;
                  tbl_ban_end[hit] = lim_now + 32'(lim_ban);
                  tbl_refill[hit] = tbl_ban_end[hit];
                  v.newly_banned = 1'b1;
               end
            end
            if (tbl_banned[hit]) begin
               d = tbl_ban_end[hit] - lim_now;
               if (d != 0 && !d[31]) v.reject = 1'b1;
               else bucket_refill(hit);
            end
         end
      end
      return v;
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req_gap <= 0;
      end else if (!req.valid || req_done) begin
         if (req_gap > 0) begin
            req.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_q.size() > 0) begin
            req_item_type it;
            it = pending_q.pop_front();
            req.valid <= 1'b1;
            req.action <= it.action;
            req.client_address <= it.client_address;
            case ($urandom_range(0, 19))
               0: req_gap <= $urandom_range(20, 200);
               1, 2, 3, 4, 5: req_gap <= $urandom_range(1, 4);
               default: req_gap <= 0;
            endcase
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // response stall control, with one long hold-off to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_gap <= 0;
         hold_left <= 0;
         held_once <= 1'b0;
      end else if (!held_once && req_accepts == 150) begin
         held_once <= 1'b1;
         hold_left <= 2500;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
         case ($urandom_range(0, 19))
            0: rsp_gap <= $urandom_range(20, 150);
            1, 2, 3, 4: rsp_gap <= $urandom_range(1, 4);
            default: rsp_gap <= 0;
         endcase
      end
   end

   // monitors: predict on accepted requests and config writes, check results
   always @(posedge clock) begin
      if (reset) begin
         req_done <= 1'b0;
         req_accepts <= 0;
         lim_bucket <= '0;
         lim_refill <= 15'd60;
         lim_ban <= 15'd900;
         lim_now <= '0;
         for (int i = 0; i < Entries; i++) tbl_valid[i] <= 1'b0;
      end else begin
         req_done <= req.valid && req.ready;
         if (csr.valid && csr.ready) begin
            case (csr.index)
               patb_pkg::REG_BUCKET: lim_bucket = csr.data;
               patb_pkg::REG_REFILL: lim_refill = csr.data;
               patb_pkg::REG_BAN: lim_ban = csr.data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            req_accepts <= req_accepts + 1;
            if (req.action == patb_pkg::ACT_TICK) sweep_table();
            else verdict_q.push_back(judge_request(req.client_address));
         end
         if (rsp.valid && rsp.ready) begin
            if (verdict_q.size() == 0) begin
               $error("result with no pending request");
               fail_count++;
            end else begin
               verdict_type want;
               want = verdict_q.pop_front();
               if (rsp.reject !== want.reject) begin
                  $error("reject: expected %0d got %0d", want.reject, rsp.reject);
                  fail_count++;
               end
               if (rsp.newly_banned !== want.newly_banned) begin
                  $error("newly_banned: expected %0d got %0d",
                         want.newly_banned, rsp.newly_banned);
                  fail_count++;
               end
               if (rsp.table_full !== want.table_full) begin
                  $error("table_full: expected %0d got %0d", want.table_full, rsp.table_full);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_req(input logic [31:0] addr);
      pending_q.push_back('{action: patb_pkg::ACT_REQUEST, client_address: addr});
   endtask

   task automatic push_tick();
      pending_q.push_back('{action: patb_pkg::ACT_TICK, client_address: $urandom});
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   // block is idle once nothing waits and it offers ready again (tick sweep done)
   task automatic wait_drained();
      while (pending_q.size() > 0 || req.valid || verdict_q.size() > 0 || !req.ready)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limits(input logic [14:0] b, input logic [14:0] r, input logic [14:0] n);
      write_reg(patb_pkg::REG_BUCKET, b);
      write_reg(patb_pkg::REG_REFILL, r);
      write_reg(patb_pkg::REG_BAN, n);
   endtask

   // random traffic over a pool of addresses; large pools overflow the table
   task automatic random_traffic(input int count, input int pool_size, input int tick_pct);
      logic [31:0] pool[$];
      for (int i = 0; i < pool_size; i++) pool.push_back($urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < tick_pct) push_tick();
         else if ($urandom_range(0, 19) == 0) push_req($urandom);
         else push_req(pool[$urandom_range(0, pool_size - 1)]);
      end
   endtask

   initial begin
      logic [31:0] a;
      fail_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.action = patb_pkg::ACT_REQUEST;
      req.client_address = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = patb_pkg::REG_BUCKET;
      csr.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // limiting disabled at reset
      push_req(32'h0000_0000);
      push_req(32'hFFFF_FFFF);
      push_tick();
      push_req(32'h1234_5678);
      wait_drained();

      // bucket exhaustion, ban, expiry by ticks
      set_limits(15'd3, 15'd5, 15'd4);
      a = $urandom;
      repeat (5) push_req(a);
      repeat (5) push_tick();
      push_req(a);
      push_req(32'hFFFF_FFFF);
      wait_drained();

      // zero ban length: ban starts and ends on the same request
      set_limits(15'd1, 15'd0, 15'd0);
      a = $urandom;
      repeat (3) push_req(a);
      push_tick();
      push_req(a);
      wait_drained();
      write_reg(REG_SPARE, 15'($urandom));

      random_traffic(110, 8, 15);
      wait_drained();
      set_limits(15'd3, 15'd5, 15'd4);
      random_traffic(110, 6, 25);
      wait_drained();
      // bucket shrinks while entries are live
      write_reg(patb_pkg::REG_BUCKET, 15'd1);
      random_traffic(90, 5, 20);
      wait_drained();
      set_limits(15'h7FFF, 15'h7FFF, 15'h7FFF);
      random_traffic(110, 90, 3);
      wait_drained();
      set_limits(15'd2, 15'd2, 15'd3);
      random_traffic(110, 80, 8);
      wait_drained();
      set_limits(15'd5, 15'd1, 15'd10);
      random_traffic(110, 4, 30);
      wait_drained();
      write_reg(patb_pkg::REG_BUCKET, 15'd0);
      random_traffic(30, 6, 20);
      wait_drained();
      set_limits(15'd7, 15'd60, 15'd900);
      random_traffic(80, 10, 10);
      wait_drained();

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
